// ----- hdl/frame_table_clock_replacement_unit_assert.svh -----
// Assertion macros shared by the frame table clock replacement RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef FRAME_TABLE_CLOCK_REPLACEMENT_UNIT_ASSERT_SVH
`define FRAME_TABLE_CLOCK_REPLACEMENT_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FTCR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define FTCR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hdl/ftcr_pkg.sv -----
// Types and codes for the frame table clock replacement unit.
// Depends on nothing; used by the top level.
`default_nettype none
package ftcr_pkg;
   localparam logic [1:0] OP_ACCESS = 2'd0;
   localparam logic [1:0] OP_TLB_EVICT = 2'd1;
   localparam logic [1:0] OP_FREE = 2'd2;

   localparam logic [2:0] ST_HIT = 3'd0;
   localparam logic [2:0] ST_LOADED_FREE = 3'd1;
   localparam logic [2:0] ST_LOADED_EVICT = 3'd2;
   localparam logic [2:0] ST_NO_VICTIM = 3'd3;
   localparam logic [2:0] ST_TLB_CLEARED = 3'd4;
   localparam logic [2:0] ST_NOT_FOUND = 3'd5;
   localparam logic [2:0] ST_FREED = 3'd6;

   localparam logic REG_FRAMES_IN_USE = 1'b0;
   localparam logic REG_BASE_PADDR = 1'b1;

   localparam int ENTRY_BITS = 38;

   typedef struct packed {
      logic        valid;
      logic        referenced;
      logic        in_tlb;
      logic [19:0] page;
      logic [14:0] owner;
   } entry_type;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_DECIDE = 7'b0001000,
      S_SW_RD  = 7'b0010000,
      S_SW_EV  = 7'b0100000,
      S_RESP   = 7'b1000000
   } state_type;
endpackage
`default_nettype wire

// ----- hdl/ftcr_frame_mem.sv -----
// Frame entry memory: one write port, one registered read port.
// Depends on nothing; instantiated by the top level.
`default_nettype none
module ftcr_frame_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 38
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hdl/frame_table_clock_replacement_unit.sv -----
// Top level of the frame table clock replacement unit.
// Depends on ftcr_pkg, ftcr_frame_mem and the assertion macro header.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  opcode, virtual_page, process_id
//   rsp      out        rsp_valid / rsp_stall  status, frame_index, phys_addr,
//                                              evicted_page, evicted_process
//   csr      in/out     psel/penable/pready    paddr, pwdata, prdata
//
// One item at a time. Every item scans the N active frames, one memory read a
// cycle. An access that misses with no free frame adds a clock sweep, up to 2N
// frame visits. After reset a clearing pass writes every entry before the
// first item is taken. A stalled result holds the block until it is taken.
`default_nettype none
`include "frame_table_clock_replacement_unit_assert.svh"
module frame_table_clock_replacement_unit #(
   parameter int FRAMES = 256,
   parameter int PAGE_BYTES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [19:0] req_virtual_page,
   input  wire logic [14:0] req_process_id,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_frame_index,
   output logic [31:0]      rsp_phys_addr,
   output logic [19:0]      rsp_evicted_page,
   output logic [14:0]      rsp_evicted_process,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int IW = $clog2(FRAMES);
   localparam int NW = $clog2(FRAMES + 1);

   ftcr_pkg::state_type state_ff, state_in;
   logic [8:0]   frames_ff;
   logic [31:0]  base_ff;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic         ev_vld_ff, ev_vld_in;
   logic [IW-1:0] ev_idx_ff, ev_idx_in;
   logic [1:0]   op_ff;
   logic [19:0]  page_ff;
   logic [14:0]  pid_ff;
   logic         fm_ff, fm_in, ff_ff, ff_in;
   logic [IW-1:0] m_idx_ff, m_idx_in, f_idx_ff, f_idx_in;
   ftcr_pkg::entry_type m_ent_ff, m_ent_in;
   logic [IW-1:0] hand_ff, hand_in, pos_ff, pos_in;
   logic [NW:0]  visits_ff, visits_in;
   logic         rv_ff, rv_in;
   logic [2:0]   rs_ff, rs_in;
   logic [IW-1:0] ri_ff, ri_in;
   logic [19:0]  rep_ff, rep_in;
   logic [14:0]  rpr_ff, rpr_in;

   logic [NW-1:0] n_act;
   logic [IW-1:0] rd_addr, wr_addr;
   logic         wr_en;
   ftcr_pkg::entry_type wr_ent, rd_ent, inst_ent;
   logic [ftcr_pkg::ENTRY_BITS-1:0] rd_word;
   logic         req_acc, rsp_acc, hit_now;
   logic [IW-1:0] pos_next;

   always_comb begin
      if (frames_ff == 9'd0) begin
         n_act = NW'(1);
      end else if (32'(frames_ff) > 32'(FRAMES)) begin
         n_act = NW'(FRAMES);
      end else begin
         n_act = NW'(frames_ff);
      end
   end

   assign req_stall = (state_ff != ftcr_pkg::S_IDLE);
   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rv_ff && !rsp_stall;
   assign rd_ent = ftcr_pkg::entry_type'(rd_word);
   assign hit_now = rd_ent.valid && rd_ent.page == page_ff && rd_ent.owner == pid_ff;
   assign pos_next = (NW'(pos_ff) == n_act - NW'(1)) ? '0 : pos_ff + IW'(1);
   assign inst_ent = '{valid: 1'b1, referenced: 1'b0, in_tlb: 1'b1,
                       page: page_ff, owner: pid_ff};

   ftcr_frame_mem #(.DEPTH(FRAMES), .WIDTH(ftcr_pkg::ENTRY_BITS)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_ent),
      .rd_addr(rd_addr), .rd_data(rd_word)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ev_vld_in = 1'b0;
      ev_idx_in = ev_idx_ff;
      fm_in = fm_ff;
      ff_in = ff_ff;
      m_idx_in = m_idx_ff;
      f_idx_in = f_idx_ff;
      m_ent_in = m_ent_ff;
      hand_in = hand_ff;
      pos_in = pos_ff;
      visits_in = visits_ff;
      rv_in = rv_ff;
      rs_in = rs_ff;
      ri_in = ri_ff;
      rep_in = rep_ff;
      rpr_in = rpr_ff;
      rd_addr = cnt_ff[IW-1:0];
      wr_en = 1'b0;
      wr_addr = cnt_ff[IW-1:0];
      wr_ent = '0;
      case (state_ff)
         ftcr_pkg::S_CLEAR: begin
            wr_en = 1'b1;
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == NW'(FRAMES - 1)) begin
               state_in = ftcr_pkg::S_IDLE;
            end
         end
         ftcr_pkg::S_IDLE: begin
            if (req_acc) begin
               state_in = ftcr_pkg::S_SCAN;
               cnt_in = '0;
               fm_in = 1'b0;
               ff_in = 1'b0;
            end
         end
         ftcr_pkg::S_SCAN: begin
            if (cnt_ff < n_act) begin
               ev_vld_in = 1'b1;
               ev_idx_in = cnt_ff[IW-1:0];
               cnt_in = cnt_ff + NW'(1);
            end else if (!ev_vld_ff) begin
               state_in = ftcr_pkg::S_DECIDE;
            end
            if (ev_vld_ff) begin
               if (hit_now && !fm_ff) begin
                  fm_in = 1'b1;
                  m_idx_in = ev_idx_ff;
                  m_ent_in = rd_ent;
               end
               if (!rd_ent.valid && !ff_ff) begin
                  ff_in = 1'b1;
                  f_idx_in = ev_idx_ff;
               end
               if (op_ff == ftcr_pkg::OP_FREE && rd_ent.valid && rd_ent.owner == pid_ff) begin
                  wr_en = 1'b1;
                  wr_addr = ev_idx_ff;
               end
            end
         end
         ftcr_pkg::S_DECIDE: begin
            state_in = ftcr_pkg::S_RESP;
            rv_in = 1'b1;
            ri_in = '0;
            rep_in = '0;
            rpr_in = '0;
            rs_in = ftcr_pkg::ST_NOT_FOUND;
            if (op_ff == ftcr_pkg::OP_ACCESS) begin
               if (fm_ff) begin
                  rs_in = ftcr_pkg::ST_HIT;
                  ri_in = m_idx_ff;
                  wr_en = 1'b1;
                  wr_addr = m_idx_ff;
                  wr_ent = m_ent_ff;
                  wr_ent.in_tlb = 1'b1;
               end else if (ff_ff) begin
                  rs_in = ftcr_pkg::ST_LOADED_FREE;
                  ri_in = f_idx_ff;
                  wr_en = 1'b1;
                  wr_addr = f_idx_ff;
                  wr_ent = inst_ent;
               end else begin
                  state_in = ftcr_pkg::S_SW_RD;
                  rv_in = 1'b0;
                  pos_in = (NW'(hand_ff) < n_act) ? hand_ff : '0;
                  visits_in = '0;
               end
            end else if (op_ff == ftcr_pkg::OP_TLB_EVICT) begin
               if (fm_ff) begin
                  rs_in = ftcr_pkg::ST_TLB_CLEARED;
                  ri_in = m_idx_ff;
                  wr_en = 1'b1;
                  wr_addr = m_idx_ff;
                  wr_ent = m_ent_ff;
                  wr_ent.in_tlb = 1'b0;
                  wr_ent.referenced = 1'b1;
               end
            end else if (op_ff == ftcr_pkg::OP_FREE) begin
               rs_in = ftcr_pkg::ST_FREED;
            end
         end
         ftcr_pkg::S_SW_RD: begin
            rd_addr = pos_ff;
            state_in = ftcr_pkg::S_SW_EV;
         end
         ftcr_pkg::S_SW_EV: begin
            wr_addr = pos_ff;
            state_in = ftcr_pkg::S_SW_RD;
            pos_in = pos_next;
            visits_in = visits_ff + (NW+1)'(1);
            if (!rd_ent.in_tlb && !rd_ent.referenced) begin
               wr_en = 1'b1;
               wr_ent = inst_ent;
               hand_in = pos_next;
               state_in = ftcr_pkg::S_RESP;
               rv_in = 1'b1;
               rs_in = ftcr_pkg::ST_LOADED_EVICT;
               ri_in = pos_ff;
               rep_in = rd_ent.page;
               rpr_in = rd_ent.owner;
            end else begin
               if (!rd_ent.in_tlb) begin
                  wr_en = 1'b1;
                  wr_ent = rd_ent;
                  wr_ent.referenced = 1'b0;
               end
               if (visits_ff == {n_act, 1'b0} - (NW+1)'(1)) begin
                  state_in = ftcr_pkg::S_RESP;
                  rv_in = 1'b1;
                  rs_in = ftcr_pkg::ST_NO_VICTIM;
                  ri_in = '0;
                  rep_in = '0;
                  rpr_in = '0;
               end
            end
         end
         ftcr_pkg::S_RESP: begin
            if (rsp_acc) begin
               rv_in = 1'b0;
               state_in = ftcr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ftcr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ftcr_pkg::S_CLEAR;
         cnt_ff <= '0;
         ev_vld_ff <= 1'b0;
         fm_ff <= 1'b0;
         ff_ff <= 1'b0;
         hand_ff <= '0;
         rv_ff <= 1'b0;
         frames_ff <= 9'd256;
         base_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ev_vld_ff <= ev_vld_in;
         fm_ff <= fm_in;
         ff_ff <= ff_in;
         hand_ff <= hand_in;
         rv_ff <= rv_in;
         if (psel && penable && pwrite) begin
            if (paddr[2] == ftcr_pkg::REG_FRAMES_IN_USE) begin
               frames_ff <= pwdata[8:0];
            end else begin
               base_ff <= pwdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff <= ev_idx_in;
      m_idx_ff <= m_idx_in;
      f_idx_ff <= f_idx_in;
      m_ent_ff <= m_ent_in;
      pos_ff <= pos_in;
      visits_ff <= visits_in;
      rs_ff <= rs_in;
      ri_ff <= ri_in;
      rep_ff <= rep_in;
      rpr_ff <= rpr_in;
      if (req_acc) begin
         op_ff <= req_opcode;
         page_ff <= req_virtual_page;
         pid_ff <= req_process_id;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == ftcr_pkg::REG_BASE_PADDR) ? base_ff : {23'd0, frames_ff};
   assign rsp_valid = rv_ff;
   assign rsp_status = rs_ff;
   assign rsp_frame_index = 8'(ri_ff);
   assign rsp_phys_addr = (rs_ff == ftcr_pkg::ST_NO_VICTIM || rs_ff == ftcr_pkg::ST_NOT_FOUND
                           || rs_ff == ftcr_pkg::ST_FREED) ? 32'd0
                          : base_ff + 32'(32'(ri_ff) * 32'(PAGE_BYTES));
   assign rsp_evicted_page = rep_ff;
   assign rsp_evicted_process = rpr_ff;

   `FTCR_ASSERT_IMPL(a_rsp_in_resp, clock, reset, rv_ff, state_ff == ftcr_pkg::S_RESP)
   `FTCR_ASSERT_NEXT(a_acc_scans, clock, reset, req_acc, state_ff == ftcr_pkg::S_SCAN)
   `FTCR_ASSERT_IMPL(a_sweep_bound, clock, reset, state_ff == ftcr_pkg::S_SW_EV,
                     visits_ff < {n_act, 1'b0})
endmodule
`default_nettype wire
